/* design/smf_pkg.sv */
// Shared constants, types and the weight power function of the separable moment filter.
// Used by the filter top and its cells; depends on nothing else.
package smf_pkg;

    localparam int MAX_HALF_WIDTH   = 7;
    localparam int MAX_ORDER        = 7;
    localparam int MAX_IMAGE_WIDTH  = 1024;
    localparam int MAX_IMAGE_HEIGHT = 1024;
    localparam int PIXEL_BITS       = 8;

    localparam int LINE_SLOTS    = 2 * MAX_HALF_WIDTH + 1;
    localparam int HW_BITS       = $clog2(MAX_HALF_WIDTH + 1);
    localparam int SLOT_BITS     = $clog2(LINE_SLOTS);
    localparam int CNT_SLOT_BITS = $clog2(LINE_SLOTS + 1);
    localparam int K_BITS        = SLOT_BITS + 1;
    localparam int COL_BITS      = $clog2(MAX_IMAGE_WIDTH);
    localparam int ROW_BITS      = $clog2(MAX_IMAGE_HEIGHT);
    localparam int ADDR_BITS     = SLOT_BITS + COL_BITS;

    localparam int ORDER_BITS    = 3;
    localparam int CFG_BITS      = 11;
    localparam int CFG_IDX_BITS  = 3;
    localparam int WEIGHT_BITS   = 21;
    localparam int PROD_BITS     = PIXEL_BITS + 1 + WEIGHT_BITS;
    localparam int ROW_SUM_BITS  = 32;
    localparam int VPROD_BITS    = ROW_SUM_BITS + WEIGHT_BITS;
    localparam int MOMENT_BITS   = 52;
    localparam int POS_BITS      = 10;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_ORDER_X      = 3'd0;
    localparam cfg_idx_t REG_ORDER_Y      = 3'd1;
    localparam cfg_idx_t REG_HALF_WIDTH   = 3'd2;
    localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd3;
    localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd4;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic int pow_const(input int kk, input int pp);
        int acc;
        acc = 1;
        for (int j = 0; j < pp; j++) begin
            acc = acc * kk;
        end
        return acc;
    endfunction

    // k to the power p as a constant table, with 0^0 = 1; offsets beyond the widest
    // window give 0.
    function automatic logic signed [WEIGHT_BITS-1:0] pow_w(
        input logic signed [K_BITS-1:0] k,
        input logic [ORDER_BITS-1:0]    p
    );
        logic signed [WEIGHT_BITS-1:0] res;
        res = '0;
        for (int kk = -MAX_HALF_WIDTH; kk <= MAX_HALF_WIDTH; kk++) begin
            for (int pp = 0; pp <= MAX_ORDER; pp++) begin
                if (int'(k) == kk && int'(p) == pp) begin
                    res = WEIGHT_BITS'(pow_const(kk, pp));
                end
            end
        end
        return res;
    endfunction

endpackage

/* design/separable_moment_filter.sv */
// Separable local moment filter, one pixel in flight at a time: a pixel is accepted, its
// horizontal sum ripples down the cell chain into the line store, and the result is handed
// off; pixels with a result first run a vertical pass, which reads the line store one
// row sum per cycle, and the hand-off waits on m_tready.
// Reset (aresetn low, synchronous) restores the default registers and starts a new frame.
// The line store needs no clearing pass. Depends on smf_pkg, smf_cell and smf_ram.
module separable_moment_filter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // pixel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [71:0]                          m_tdata,   // moment_value, pos_x, pos_y
    output logic                                 m_tlast,   // frame_last
    input  logic                                 cfg_we,
    input  logic [smf_pkg::CFG_IDX_BITS-1:0]     cfg_addr,
    input  logic [smf_pkg::CFG_BITS-1:0]         cfg_wdata
);
    import smf_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_HSUM, ST_VREAD, ST_DONE} state_t;
    localparam int HSUM_WAIT = LINE_SLOTS + 2;
    localparam int WAIT_BITS = $clog2(HSUM_WAIT + 1);

    state_t state_reg;
    logic [ORDER_BITS-1:0] ox_reg, oy_reg;
    logic [2:0]            hw_reg;
    logic [CFG_BITS-1:0]   iw_reg, ih_reg;

    logic [HW_BITS-1:0]       h_eff;
    logic [COL_BITS:0]        w_eff;
    logic [ROW_BITS:0]        ht_eff;
    logic [SLOT_BITS-1:0]     two_h;
    logic [CNT_SLOT_BITS-1:0] span;

    logic [COL_BITS-1:0]  col_reg;
    logic [ROW_BITS-1:0]  row_reg;
    logic [SLOT_BITS-1:0] row_slot_reg, rd_slot_reg, vidx_b_reg;
    logic [WAIT_BITS-1:0] wait_reg;
    logic [CNT_SLOT_BITS-1:0] iss_cnt_reg;
    logic do_h_reg, do_v_reg, last_reg, row_end_reg, vb_reg, vc_reg;
    logic [COL_BITS-1:0] cx_reg;
    logic [ROW_BITS-1:0] cy_reg;
    logic signed [VPROD_BITS-1:0]  vprod_reg;
    logic signed [MOMENT_BITS-1:0] acc_reg;
    logic signed [WEIGHT_BITS-1:0] vw_reg [LINE_SLOTS];
    logic m_tvalid_reg, m_tlast_reg;
    logic [71:0] m_data_reg;

    logic accept, restart, done_fire, hsum_end, rd_en, wr_en;
    logic [ADDR_BITS-1:0] wr_addr, rd_addr;
    logic [ROW_SUM_BITS-1:0] rd_data;
    cell_ctrl_t cell_ctrl;
    logic [PIXEL_BITS-1:0] pix_chain [LINE_SLOTS+1];
    logic signed [ROW_SUM_BITS-1:0] psum_chain [LINE_SLOTS+1];

    assign h_eff  = (int'(hw_reg) > MAX_HALF_WIDTH) ? HW_BITS'(MAX_HALF_WIDTH) : HW_BITS'(hw_reg);
    assign w_eff  = (iw_reg == '0) ? (COL_BITS+1)'(1) :
                    (int'(iw_reg) > MAX_IMAGE_WIDTH) ? (COL_BITS+1)'(MAX_IMAGE_WIDTH) :
                    (COL_BITS+1)'(iw_reg);
    assign ht_eff = (ih_reg == '0) ? (ROW_BITS+1)'(1) :
                    (int'(ih_reg) > MAX_IMAGE_HEIGHT) ? (ROW_BITS+1)'(MAX_IMAGE_HEIGHT) :
                    (ROW_BITS+1)'(ih_reg);
    assign two_h  = SLOT_BITS'({h_eff, 1'b0});
    assign span   = CNT_SLOT_BITS'(two_h) + CNT_SLOT_BITS'(1);

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_we;
    assign accept    = s_tvalid && s_tready;
    assign restart   = cfg_we && (int'(cfg_addr) <= int'(REG_IMAGE_HEIGHT));
    assign done_fire = (state_reg == ST_DONE) && (!do_v_reg || !m_tvalid_reg || m_tready);
    assign hsum_end  = (state_reg == ST_HSUM) && (wait_reg == WAIT_BITS'(HSUM_WAIT));
    assign rd_en     = (state_reg == ST_VREAD) && (iss_cnt_reg < span);
    assign wr_en     = hsum_end && do_h_reg;
    assign wr_addr   = {row_slot_reg, cx_reg};
    assign rd_addr   = {rd_slot_reg, cx_reg};

    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = restart || (done_fire && row_end_reg);

    assign pix_chain[0]  = s_tdata[PIXEL_BITS-1:0];
    assign psum_chain[0] = '0;

    for (genvar j = 0; j < LINE_SLOTS; j++) begin : g_cell
        logic signed [K_BITS-1:0] k_j;
        assign k_j = $signed(K_BITS'(h_eff)) - $signed(K_BITS'(j));
        smf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .active   (SLOT_BITS'(j) <= two_h),
            .k        (k_j),
            .order    (ox_reg),
            .pix_in   (pix_chain[j]),
            .pix_out  (pix_chain[j+1]),
            .psum_in  (psum_chain[j]),
            .psum_out (psum_chain[j+1])
        );
    end

    smf_ram #(
        .WIDTH     (ROW_SUM_BITS),
        .DEPTH     (2 ** ADDR_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_lines (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (psum_chain[LINE_SLOTS]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LINE_SLOTS; i++) begin
            vw_reg[i] <= (SLOT_BITS'(i) <= two_h) ?
                pow_w($signed(K_BITS'(i)) - $signed(K_BITS'(h_eff)), oy_reg) : '0;
        end

        vb_reg     <= rd_en && aresetn;
        vidx_b_reg <= iss_cnt_reg[SLOT_BITS-1:0];
        vc_reg     <= vb_reg && aresetn;
        vprod_reg  <= $signed(rd_data) * vw_reg[vidx_b_reg];

        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ox_reg       <= ORDER_BITS'(1);
            oy_reg       <= ORDER_BITS'(1);
            hw_reg       <= 3'd1;
            iw_reg       <= CFG_BITS'(640);
            ih_reg       <= CFG_BITS'(480);
            col_reg      <= '0;
            row_reg      <= '0;
            row_slot_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (restart) begin
            unique case (cfg_addr)
                REG_ORDER_X:      ox_reg <= cfg_wdata[ORDER_BITS-1:0];
                REG_ORDER_Y:      oy_reg <= cfg_wdata[ORDER_BITS-1:0];
                REG_HALF_WIDTH:   hw_reg <= cfg_wdata[2:0];
                REG_IMAGE_WIDTH:  iw_reg <= cfg_wdata;
                REG_IMAGE_HEIGHT: ih_reg <= cfg_wdata;
                default: ;
            endcase
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            row_slot_reg <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && !(done_fire && do_v_reg)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        do_h_reg <= ((COL_BITS+1)'(col_reg) >= (COL_BITS+1)'(two_h)) &&
                                    ((COL_BITS+1)'(col_reg) < w_eff) &&
                                    ((ROW_BITS+1)'(row_reg) < ht_eff);
                        do_v_reg <= ((COL_BITS+1)'(col_reg) >= (COL_BITS+1)'(two_h)) &&
                                    ((COL_BITS+1)'(col_reg) < w_eff) &&
                                    ((ROW_BITS+1)'(row_reg) < ht_eff) &&
                                    ((ROW_BITS+1)'(row_reg) >= (ROW_BITS+1)'(two_h));
                        cx_reg <= col_reg - COL_BITS'(h_eff);
                        cy_reg <= row_reg - ROW_BITS'(h_eff);
                        row_end_reg <= ((COL_BITS+1)'(col_reg) + 1'b1) >= w_eff;
                        last_reg <= (((COL_BITS+1)'(col_reg) + 1'b1) == w_eff) &&
                                    (((ROW_BITS+1)'(row_reg) + 1'b1) == ht_eff);
                        wait_reg  <= '0;
                        state_reg <= ST_HSUM;
                    end
                end
                ST_HSUM: begin
                    wait_reg <= wait_reg + 1'b1;
                    if (hsum_end) begin
                        iss_cnt_reg <= '0;
                        acc_reg     <= '0;
                        rd_slot_reg <= (row_slot_reg == two_h) ? '0 : row_slot_reg + 1'b1;
                        state_reg   <= do_v_reg ? ST_VREAD : ST_DONE;
                    end
                end
                ST_VREAD: begin
                    if (rd_en) begin
                        iss_cnt_reg <= iss_cnt_reg + 1'b1;
                        rd_slot_reg <= (rd_slot_reg == two_h) ? '0 : rd_slot_reg + 1'b1;
                    end
                    if (vc_reg) begin
                        acc_reg <= acc_reg + MOMENT_BITS'(vprod_reg);
                    end
                    if (!rd_en && !vb_reg && !vc_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (done_fire) begin
                        if (do_v_reg) begin
                            m_tvalid_reg <= 1'b1;
                            m_data_reg   <= {POS_BITS'(cy_reg), POS_BITS'(cx_reg), acc_reg};
                            m_tlast_reg  <= last_reg;
                        end
                        if (row_end_reg) begin
                            col_reg <= '0;
                            if ((ROW_BITS+1)'(row_reg) + 1'b1 >= ht_eff) begin
                                row_reg      <= '0;
                                row_slot_reg <= '0;
                            end else begin
                                row_reg      <= row_reg + 1'b1;
                                row_slot_reg <= (row_slot_reg == two_h) ? '0 :
                                                row_slot_reg + 1'b1;
                            end
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_tlast_reg;

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (COL_BITS+1)'(col_reg) < w_eff)
        else $error("column counter beyond image width");

    a_slot_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        row_slot_reg <= two_h)
        else $error("line slot beyond window span");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iss_cnt_reg <= span || state_reg != ST_VREAD)
        else $error("vertical pass issued too many reads");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the hand-off state");

endmodule

/* design/smf_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the row-sum line store; depends on nothing else.
module smf_ram #(
    parameter int WIDTH     = 32,
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/smf_cell.sv */
// One cell of the horizontal chain: holds one pixel of the row window, its weight,
// and adds its product to the partial sum passed along the chain. Depends on smf_pkg.
module smf_cell (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  smf_pkg::cell_ctrl_t                       ctrl,
    input  logic                                      active,
    input  logic signed [smf_pkg::K_BITS-1:0]         k,
    input  logic [smf_pkg::ORDER_BITS-1:0]            order,
    input  logic [smf_pkg::PIXEL_BITS-1:0]            pix_in,
    output logic [smf_pkg::PIXEL_BITS-1:0]            pix_out,
    input  logic signed [smf_pkg::ROW_SUM_BITS-1:0]   psum_in,
    output logic signed [smf_pkg::ROW_SUM_BITS-1:0]   psum_out
);
    import smf_pkg::*;

    logic [PIXEL_BITS-1:0]          pix_reg;
    logic signed [WEIGHT_BITS-1:0]  weight_reg;
    logic signed [PROD_BITS-1:0]    prod_reg;
    logic signed [ROW_SUM_BITS-1:0] psum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            pix_reg <= '0;
        end else if (ctrl.shift) begin
            pix_reg <= pix_in;
        end
        weight_reg <= active ? pow_w(k, order) : '0;
        prod_reg   <= PROD_BITS'($signed({1'b0, pix_reg}) * weight_reg);
        psum_reg   <= psum_in + ROW_SUM_BITS'(prod_reg);
    end

    assign pix_out  = pix_reg;
    assign psum_out = psum_reg;

endmodule
